FILE: rtl/rigid_transform_engine_assert.svh
// assertion macros for the rigid transform engine
// expects clk and rst in the scope of each use
`ifndef RIGID_TRANSFORM_ENGINE_ASSERT_SVH
`define RIGID_TRANSFORM_ENGINE_ASSERT_SVH

// same-cycle implication
`define RTE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rigid transform engine check failed");

// next-cycle implication
`define RTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rigid transform engine check failed");

`endif

FILE: rtl/rte_pkg.sv
// shared types, opcodes and constants of the rigid transform engine
// no dependencies
package rte_pkg;

  localparam int COEF_W     = 32;
  localparam int COEFF_FRAC = 30;
  localparam int NUM_SLOTS  = 12;
  localparam int NUM_ROT    = 9;
  localparam int SLOT_W     = 4;
  localparam int ACC_W      = 2 * COEF_W + 3;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_XFORM = 2'd1;
  localparam logic [1:0] OP_INV   = 2'd2;
  localparam logic [1:0] OP_COMP  = 2'd3;

  localparam logic BANK_CUR = 1'b0;
  localparam logic BANK_STG = 1'b1;

  localparam logic [SLOT_W-1:0] SLOT_END = SLOT_W'(NUM_SLOTS);

  localparam coef_t COEF_ONE = coef_t'(1) <<< COEFF_FRAC;
  localparam coef_t COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]        opcode;
    logic              bank;
    logic [SLOT_W-1:0] slot;
    coef_t             value;
    coef_t             px;
    coef_t             py;
    coef_t             pz;
  } cmd_word_t;

  typedef struct packed {
    coef_t qx;
    coef_t qy;
    coef_t qz;
    logic  overflow;
  } res_word_t;

  function automatic coef_t reset_coef(input int idx);
    coef_t v;
    v = (idx == 0 || idx == 4 || idx == 8) ? COEF_ONE : '0;
    return v;
  endfunction

endpackage

FILE: rtl/rte_dot3.sv
// three-term dot product with offset, half-up rounding and saturation
// depends on rte_pkg
module rte_dot3 (
  input  rte_pkg::coef_t a [3],
  input  rte_pkg::coef_t b [3],
  input  rte_pkg::coef_t c,
  input  logic           neg,
  output rte_pkg::coef_t q,
  output logic           ovf
);
  import rte_pkg::*;

  localparam int SCL_W = ACC_W - COEFF_FRAC;
  localparam int HI_W  = SCL_W - COEF_W + 1;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEFF_FRAC - 1);

  logic signed [2*COEF_W-1:0] prod [3];
  logic signed [ACC_W-1:0]    term [3];
  logic signed [ACC_W-1:0]    acc;
  logic [SCL_W-1:0]           scaled;
  logic [HI_W-1:0]            hi;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = a[k] * b[k];
      term[k] = neg ? -ACC_W'(prod[k]) : ACC_W'(prod[k]);
    end
    acc    = term[0] + term[1] + term[2] + (ACC_W'(c) <<< COEFF_FRAC) + HALF;
    scaled = acc[ACC_W-1:COEFF_FRAC];
    hi     = scaled[SCL_W-1:COEF_W-1];
    if (hi == '0 || hi == '1) begin
      q   = scaled[COEF_W-1:0];
      ovf = 1'b0;
    end else if (scaled[SCL_W-1]) begin
      q   = COEF_MIN;
      ovf = 1'b1;
    end else begin
      q   = COEF_MAX;
      ovf = 1'b1;
    end
  end

endmodule

FILE: rtl/rigid_transform_engine.sv
// rigid transform engine: current and staged 3d rigid transforms, point mapping
// accepted word held in the input register, then its result word in res (none for loads)
// one word per cycle unless res stalls; non-load ops pass once through twelve dot3 units
// reset: both matrices identity rotation with zero translation, pipeline empty
// depends on rte_pkg, rte_dot3 and rigid_transform_engine_assert.svh
module rigid_transform_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  rte_pkg::cmd_word_t cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output rte_pkg::res_word_t res
);
  import rte_pkg::*;

  logic      s1_valid;
  cmd_word_t s1;
  coef_t     cur [NUM_SLOTS];
  coef_t     stg [NUM_SLOTS];

  coef_t                unit_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] unit_ovf;

  logic advance;
  logic is_load;
  logic is_xform;
  logic is_inv;
  logic is_comp;

  assign is_load  = (s1.opcode == OP_LOAD);
  assign is_xform = (s1.opcode == OP_XFORM);
  assign is_inv   = (s1.opcode == OP_INV);
  assign is_comp  = (s1.opcode == OP_COMP);

  assign advance   = s1_valid && (is_load || !res_valid || !res_stall);
  assign cmd_stall = s1_valid && !advance;

  // rotation units for compose, translation units for transform, invert and compose
  for (genvar u = 0; u < NUM_SLOTS; u++) begin : g_unit
    localparam int I = u % 3;
    localparam int J = u / 3;
    coef_t a [3];
    coef_t b [3];
    coef_t c;
    logic  neg;

    if (u < NUM_ROT) begin : g_rot
      always_comb begin
        a[0] = cur[I];
        a[1] = cur[3+I];
        a[2] = cur[6+I];
        b[0] = stg[J*3];
        b[1] = stg[J*3+1];
        b[2] = stg[J*3+2];
        c    = '0;
        neg  = 1'b0;
      end
    end else begin : g_trn
      localparam int T = u - NUM_ROT;
      always_comb begin
        if (is_inv) begin
          a[0] = cur[T*3];
          a[1] = cur[T*3+1];
          a[2] = cur[T*3+2];
          b[0] = cur[9];
          b[1] = cur[10];
          b[2] = cur[11];
          c    = '0;
          neg  = 1'b1;
        end else begin
          a[0] = cur[T];
          a[1] = cur[3+T];
          a[2] = cur[6+T];
          if (is_xform) begin
            b[0] = s1.px;
            b[1] = s1.py;
            b[2] = s1.pz;
          end else begin
            b[0] = stg[9];
            b[1] = stg[10];
            b[2] = stg[11];
          end
          c   = cur[9+T];
          neg = 1'b0;
        end
      end
    end

    rte_dot3 u_dot (
      .a   (a),
      .b   (b),
      .c   (c),
      .neg (neg),
      .q   (unit_q[u]),
      .ovf (unit_ovf[u])
    );
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (cmd_valid && !cmd_stall) begin
      s1 <= cmd;
    end
  end

  // matrix state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        cur[i] <= reset_coef(i);
        stg[i] <= reset_coef(i);
      end
    end else if (advance) begin
      unique case (s1.opcode)
        OP_LOAD: begin
          if (s1.slot < SLOT_END) begin
            if (s1.bank == BANK_STG) begin
              stg[s1.slot] <= s1.value;
            end else begin
              cur[s1.slot] <= s1.value;
            end
          end
        end
        OP_XFORM: begin
        end
        OP_INV: begin
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
              cur[j*3+i] <= cur[i*3+j];
            end
            cur[9+i] <= unit_q[9+i];
          end
        end
        OP_COMP: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            cur[i] <= unit_q[i];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && !is_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (advance && !is_load) begin
      res.qx       <= is_xform ? unit_q[9]  : '0;
      res.qy       <= is_xform ? unit_q[10] : '0;
      res.qz       <= is_xform ? unit_q[11] : '0;
      res.overflow <= is_comp ? (|unit_ovf) : (|unit_ovf[NUM_SLOTS-1:NUM_ROT]);
    end
  end

  `include "rigid_transform_engine_assert.svh"

  `RTE_ASSERT_NOW(a_stall_needs_word, cmd_stall, s1_valid)
  `RTE_ASSERT_NEXT(a_load_no_result, advance && is_load && !(res_valid && res_stall), !res_valid)
  `RTE_ASSERT_NEXT(a_op_gives_result, advance && !is_load, res_valid)
  `RTE_ASSERT_NEXT(a_matrix_op_zero_point, advance && (is_inv || is_comp), res.qx == '0 && res.qy == '0 && res.qz == '0)

endmodule
